// ===== sv/kngs_pkg.sv =====
// shared types and constants for the minimum gap selection block
// no dependencies; compiled first
`default_nettype none

package kngs_pkg;

  localparam int POS_W   = 32;
  localparam int PICKS_W = 10;

  // result as handed from the engine to the output register
  typedef struct packed {
    logic [POS_W-1:0] total_length;
    logic             overflow;
  } res_t;

  // sequencer states of the engine
  typedef enum logic [5:0] {
    S_LOAD, S_INIT, S_BLD, S_BLD_NX,
    S_PU0, S_PU1,
    S_SU_CHK, S_SU_RD1, S_SU_RD2, S_SU_END,
    S_SD_LD0, S_SD_LD1, S_SD_LD2, S_SD_CHK, S_SD_R1, S_SD_R2, S_SD_R3,
    S_SD_CMP, S_SD_END,
    S_RM0, S_RM1, S_RM2, S_RM3, S_RM4,
    S_G0, S_G1, S_G2,
    S_A1, S_A2, S_A3,
    S_B1, S_B2, S_B3,
    S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== sv/kngs_if.sv =====
// request channels of the minimum gap selection block
// uses kngs_pkg for field widths
`default_nettype none

interface kngs_in_if;
  logic                       valid;
  logic                       ready;
  logic [kngs_pkg::POS_W-1:0] position;
  logic                       last_point;
  modport source(output valid, position, last_point, input ready);
  modport sink(input valid, position, last_point, output ready);
endinterface

interface kngs_out_if;
  logic                       valid;
  logic                       ready;
  logic [kngs_pkg::POS_W-1:0] total_length;
  logic                       overflow;
  modport source(output valid, total_length, overflow, input ready);
  modport sink(input valid, total_length, overflow, output ready);
endinterface

`default_nettype wire

// ===== sv/kngs_engine.sv =====
// point storage, linked gap chain, indexed min-heap and greedy sequencer
// depends on kngs_pkg and kngs_if
`default_nettype none

module kngs_engine #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  kngs_in_if.sink                      points,
  input  logic [kngs_pkg::PICKS_W-1:0] picks,
  output logic                         res_valid,
  output kngs_pkg::res_t               res,
  input  logic                         res_take
);

  localparam int IDX_W = $clog2(MAX_POINTS + 1);
  localparam int VAL_W = kngs_pkg::POS_W + IDX_W;
  localparam int DEPTH = MAX_POINTS + 1;
  localparam int PW    = kngs_pkg::PICKS_W;
  localparam logic [IDX_W-1:0] N_MAX    = IDX_W'(MAX_POINTS);
  localparam logic [IDX_W-1:0] ONE      = IDX_W'(1);
  localparam logic [IDX_W-1:0] ZERO     = '0;
  localparam logic [PW-1:0]    PICK_ONE = PW'(1);

  // node stores and heap arrays
  logic [VAL_W-1:0] gap_mem  [DEPTH];
  logic [IDX_W-1:0] prv_mem  [DEPTH];
  logic [IDX_W-1:0] nxt_mem  [DEPTH];
  logic [IDX_W-1:0] slot_mem [DEPTH];
  logic [IDX_W-1:0] whr_mem  [DEPTH];

  logic [IDX_W-1:0] gap_ra, prv_ra, nxt_ra, slot_ra, whr_ra;
  logic [IDX_W-1:0] gap_wa, prv_wa, nxt_wa, slot_wa, whr_wa;
  logic             gap_we, prv_we, nxt_we, slot_we, whr_we;
  logic [VAL_W-1:0] gap_wd, gap_q;
  logic [IDX_W-1:0] prv_wd, nxt_wd, slot_wd, whr_wd;
  logic [IDX_W-1:0] prv_q, nxt_q, slot_q, whr_q;

  kngs_pkg::state_t state, state_next;
  kngs_pkg::state_t ret1, rm_ret, push_ret;

  logic [IDX_W-1:0]   count, i, x, l, r, p, e, rp, size, lim, node, c_r, cch, sc, sc1, sch;
  logic [VAL_W-1:0]   ve, vx, vl, vc, vch, total;
  logic [PW-1:0]      rounds;
  logic [kngs_pkg::POS_W-1:0] lastpos;
  logic               ovf;
  logic               accept;
  logic [kngs_pkg::POS_W-1:0] diff;
  logic [IDX_W:0]     child2;

  assign accept = points.valid && points.ready;
  assign points.ready = (state == kngs_pkg::S_LOAD);
  assign diff = (points.position >= lastpos) ? (points.position - lastpos) : '0;
  assign child2 = {p, 1'b0};

  // result fields, saturated to the output width
  assign res_valid = (state == kngs_pkg::S_FIN);
  assign res.total_length = (total[VAL_W-1:kngs_pkg::POS_W] != '0) ? '1
                          : total[kngs_pkg::POS_W-1:0];
  assign res.overflow = ovf;

  // memory ports, registered read data
  always_ff @(posedge clk) begin
    if (gap_we) gap_mem[gap_wa] <= gap_wd;
    gap_q <= gap_mem[gap_ra];
  end
  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_q <= prv_mem[prv_ra];
  end
  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_q <= nxt_mem[nxt_ra];
  end
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_q <= slot_mem[slot_ra];
  end
  always_ff @(posedge clk) begin
    if (whr_we) whr_mem[whr_wa] <= whr_wd;
    whr_q <= whr_mem[whr_ra];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kngs_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    gap_ra = ZERO;  prv_ra = ZERO;  nxt_ra = ZERO;  slot_ra = ZERO;  whr_ra = ZERO;
    gap_we = 1'b0;  prv_we = 1'b0;  nxt_we = 1'b0;  slot_we = 1'b0;  whr_we = 1'b0;
    gap_wa = ZERO;  prv_wa = ZERO;  nxt_wa = ZERO;  slot_wa = ZERO;  whr_wa = ZERO;
    gap_wd = '0;    prv_wd = ZERO;  nxt_wd = ZERO;  slot_wd = ZERO;  whr_wd = ZERO;
    case (state)
      kngs_pkg::S_LOAD: begin
        if (accept) begin
          if (count != N_MAX && count != ZERO) begin
            gap_we = 1'b1;
            gap_wa = count;
            gap_wd = {{(VAL_W - kngs_pkg::POS_W){1'b0}}, diff};
          end
          if (points.last_point) state_next = kngs_pkg::S_INIT;
        end
      end
      kngs_pkg::S_INIT: begin
        prv_we = 1'b1;
        prv_wa = ONE;
        prv_wd = ZERO;
        state_next = kngs_pkg::S_BLD;
      end
      // chain links and heap insert of each gap
      kngs_pkg::S_BLD: begin
        if (i < count) begin
          nxt_we = 1'b1;  nxt_wa = i;        nxt_wd = i + ONE;
          prv_we = 1'b1;  prv_wa = i + ONE;  prv_wd = i;
          state_next = kngs_pkg::S_PU0;
        end else begin
          state_next = kngs_pkg::S_G0;
        end
      end
      kngs_pkg::S_BLD_NX: state_next = kngs_pkg::S_BLD;
      // heap push
      kngs_pkg::S_PU0: begin
        gap_ra = node;
        state_next = kngs_pkg::S_PU1;
      end
      kngs_pkg::S_PU1: state_next = kngs_pkg::S_SU_CHK;
      // sift up with a hole
      kngs_pkg::S_SU_CHK: begin
        if (p > ONE) begin
          slot_ra = p >> 1;
          state_next = kngs_pkg::S_SU_RD1;
        end else begin
          state_next = kngs_pkg::S_SU_END;
        end
      end
      kngs_pkg::S_SU_RD1: begin
        gap_ra = slot_q;
        state_next = kngs_pkg::S_SU_RD2;
      end
      kngs_pkg::S_SU_RD2: begin
        if (ve < gap_q) begin
          slot_we = 1'b1;  slot_wa = p;   slot_wd = sc;
          whr_we = 1'b1;   whr_wa = sc;   whr_wd = p;
          state_next = kngs_pkg::S_SU_CHK;
        end else begin
          state_next = kngs_pkg::S_SU_END;
        end
      end
      kngs_pkg::S_SU_END: begin
        slot_we = 1'b1;  slot_wa = p;  slot_wd = e;
        whr_we = 1'b1;   whr_wa = e;   whr_wd = p;
        state_next = ret1;
      end
      // sift down with a hole
      kngs_pkg::S_SD_LD0: begin
        slot_ra = p;
        state_next = kngs_pkg::S_SD_LD1;
      end
      kngs_pkg::S_SD_LD1: begin
        gap_ra = slot_q;
        state_next = kngs_pkg::S_SD_LD2;
      end
      kngs_pkg::S_SD_LD2: state_next = kngs_pkg::S_SD_CHK;
      kngs_pkg::S_SD_CHK: begin
        if (child2 <= {1'b0, lim}) begin
          slot_ra = child2[IDX_W-1:0];
          state_next = kngs_pkg::S_SD_R1;
        end else begin
          state_next = kngs_pkg::S_SD_END;
        end
      end
      kngs_pkg::S_SD_R1: begin
        gap_ra = slot_q;
        slot_ra = c_r + ONE;
        state_next = kngs_pkg::S_SD_R2;
      end
      kngs_pkg::S_SD_R2: begin
        if (c_r < lim) begin
          gap_ra = slot_q;
          state_next = kngs_pkg::S_SD_R3;
        end else begin
          state_next = kngs_pkg::S_SD_CMP;
        end
      end
      kngs_pkg::S_SD_R3: state_next = kngs_pkg::S_SD_CMP;
      kngs_pkg::S_SD_CMP: begin
        if (ve > vch) begin
          slot_we = 1'b1;  slot_wa = p;    slot_wd = sch;
          whr_we = 1'b1;   whr_wa = sch;   whr_wd = p;
          state_next = kngs_pkg::S_SD_CHK;
        end else begin
          state_next = kngs_pkg::S_SD_END;
        end
      end
      kngs_pkg::S_SD_END: begin
        slot_we = 1'b1;  slot_wa = p;  slot_wd = e;
        whr_we = 1'b1;   whr_wa = e;   whr_wd = p;
        state_next = ret1;
      end
      // heap erase by node
      kngs_pkg::S_RM0: begin
        whr_ra = node;
        state_next = kngs_pkg::S_RM1;
      end
      kngs_pkg::S_RM1: begin
        slot_ra = size;
        state_next = kngs_pkg::S_RM2;
      end
      kngs_pkg::S_RM2: begin
        gap_ra = slot_q;
        state_next = kngs_pkg::S_RM3;
      end
      kngs_pkg::S_RM3: state_next = kngs_pkg::S_SU_CHK;
      kngs_pkg::S_RM4: state_next = kngs_pkg::S_SD_LD0;
      // one greedy pick
      kngs_pkg::S_G0: begin
        if (rounds == '0 || size == ZERO) begin
          state_next = kngs_pkg::S_FIN;
        end else begin
          slot_ra = ONE;
          state_next = kngs_pkg::S_G1;
        end
      end
      kngs_pkg::S_G1: begin
        gap_ra = slot_q;
        prv_ra = slot_q;
        nxt_ra = slot_q;
        state_next = kngs_pkg::S_G2;
      end
      kngs_pkg::S_G2: begin
        if (prv_q == ZERO && nxt_q == count) state_next = kngs_pkg::S_FIN;
        else if (prv_q == ZERO || nxt_q == count) state_next = kngs_pkg::S_RM0;
        else state_next = kngs_pkg::S_C0;
      end
      // left chain end
      kngs_pkg::S_A1: state_next = kngs_pkg::S_RM0;
      kngs_pkg::S_A2: begin
        nxt_ra = r;
        state_next = kngs_pkg::S_A3;
      end
      kngs_pkg::S_A3: begin
        prv_we = 1'b1;  prv_wa = nxt_q;  prv_wd = ZERO;
        state_next = kngs_pkg::S_G0;
      end
      // right chain end
      kngs_pkg::S_B1: state_next = kngs_pkg::S_RM0;
      kngs_pkg::S_B2: begin
        prv_ra = l;
        state_next = kngs_pkg::S_B3;
      end
      kngs_pkg::S_B3: begin
        nxt_we = 1'b1;  nxt_wa = prv_q;  nxt_wd = count;
        state_next = kngs_pkg::S_G0;
      end
      // inner gap merge
      kngs_pkg::S_C0: begin
        gap_ra = l;
        state_next = kngs_pkg::S_C1;
      end
      kngs_pkg::S_C1: begin
        gap_ra = r;
        state_next = kngs_pkg::S_C2;
      end
      kngs_pkg::S_C2: state_next = kngs_pkg::S_C3;
      kngs_pkg::S_C3: begin
        gap_we = 1'b1;  gap_wa = x;  gap_wd = vl - vx;
        state_next = kngs_pkg::S_RM0;
      end
      kngs_pkg::S_C4: state_next = kngs_pkg::S_RM0;
      kngs_pkg::S_C5: state_next = kngs_pkg::S_RM0;
      kngs_pkg::S_C6: state_next = kngs_pkg::S_PU0;
      kngs_pkg::S_C7: begin
        prv_ra = l;
        nxt_ra = r;
        state_next = kngs_pkg::S_C8;
      end
      kngs_pkg::S_C8: begin
        prv_we = 1'b1;  prv_wa = x;  prv_wd = prv_q;
        nxt_we = 1'b1;  nxt_wa = x;  nxt_wd = nxt_q;
        state_next = kngs_pkg::S_C9;
      end
      kngs_pkg::S_C9: begin
        nxt_we = 1'b1;  nxt_wa = l;  nxt_wd = x;
        prv_we = 1'b1;  prv_wa = r;  prv_wd = x;
        state_next = kngs_pkg::S_G0;
      end
      kngs_pkg::S_FIN: begin
        if (res_take) state_next = kngs_pkg::S_LOAD;
      end
      default: state_next = kngs_pkg::S_LOAD;
    endcase
  end

  // set bookkeeping, cleared by reset and after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= ZERO;
      lastpos <= '0;
      total   <= '0;
      ovf     <= 1'b0;
      size    <= ZERO;
    end else begin
      case (state)
        kngs_pkg::S_LOAD: begin
          if (accept) begin
            if (count == N_MAX) begin
              ovf <= 1'b1;
            end else begin
              lastpos <= points.position;
              count   <= count + ONE;
            end
          end
        end
        kngs_pkg::S_INIT: size <= ZERO;
        kngs_pkg::S_PU1:  size <= size + ONE;
        kngs_pkg::S_RM4:  size <= size - ONE;
        kngs_pkg::S_G2:   total <= total + gap_q;
        kngs_pkg::S_FIN: begin
          if (res_take) begin
            count   <= ZERO;
            lastpos <= '0;
            total   <= '0;
            ovf     <= 1'b0;
            size    <= ZERO;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      kngs_pkg::S_INIT: begin
        rounds <= picks;
        i      <= ONE;
      end
      kngs_pkg::S_BLD: begin
        node     <= i;
        push_ret <= kngs_pkg::S_BLD_NX;
      end
      kngs_pkg::S_BLD_NX: i <= i + ONE;
      kngs_pkg::S_PU1: begin
        e    <= node;
        ve   <= gap_q;
        p    <= size + ONE;
        ret1 <= push_ret;
      end
      kngs_pkg::S_SU_RD1: sc <= slot_q;
      kngs_pkg::S_SU_RD2: begin
        if (ve < gap_q) p <= p >> 1;
      end
      kngs_pkg::S_SD_LD1: e  <= slot_q;
      kngs_pkg::S_SD_LD2: ve <= gap_q;
      kngs_pkg::S_SD_CHK: c_r <= child2[IDX_W-1:0];
      kngs_pkg::S_SD_R1:  sc  <= slot_q;
      kngs_pkg::S_SD_R2: begin
        vc  <= gap_q;
        sc1 <= slot_q;
        cch <= c_r;
        sch <= sc;
        vch <= gap_q;
      end
      kngs_pkg::S_SD_R3: begin
        if (vc > gap_q) begin
          cch <= c_r + ONE;
          sch <= sc1;
          vch <= gap_q;
        end
      end
      kngs_pkg::S_SD_CMP: begin
        if (ve > vch) p <= cch;
      end
      kngs_pkg::S_RM1: rp <= whr_q;
      kngs_pkg::S_RM2: e  <= slot_q;
      kngs_pkg::S_RM3: begin
        ve   <= gap_q;
        p    <= rp;
        ret1 <= kngs_pkg::S_RM4;
      end
      kngs_pkg::S_RM4: begin
        lim  <= size - ONE;
        p    <= rp;
        ret1 <= rm_ret;
      end
      kngs_pkg::S_G1: x <= slot_q;
      kngs_pkg::S_G2: begin
        vx     <= gap_q;
        l      <= prv_q;
        r      <= nxt_q;
        rounds <= rounds - PICK_ONE;
        node   <= x;
        rm_ret <= (prv_q == ZERO) ? kngs_pkg::S_A1 : kngs_pkg::S_B1;
      end
      kngs_pkg::S_A1: begin
        node   <= r;
        rm_ret <= kngs_pkg::S_A2;
      end
      kngs_pkg::S_B1: begin
        node   <= l;
        rm_ret <= kngs_pkg::S_B2;
      end
      kngs_pkg::S_C1: vl <= gap_q;
      kngs_pkg::S_C2: vl <= vl + gap_q;
      kngs_pkg::S_C3: begin
        node   <= x;
        rm_ret <= kngs_pkg::S_C4;
      end
      kngs_pkg::S_C4: begin
        node   <= l;
        rm_ret <= kngs_pkg::S_C5;
      end
      kngs_pkg::S_C5: begin
        node   <= r;
        rm_ret <= kngs_pkg::S_C6;
      end
      kngs_pkg::S_C6: begin
        node     <= x;
        push_ret <= kngs_pkg::S_C7;
      end
      kngs_pkg::S_C8: begin
        l <= prv_q;
        r <= nxt_q;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/k_nonadjacent_min_gap_select.sv =====
// points load at one per cycle while the engine is in its load state; after the
// closing point the engine builds the heap, then makes each pick, either at a chain
// end or as an inner merge, with heap erases and inserts that climb and descend
// levels (single read port each).
// points are taken again once the result moves to the output register.
// synchronous reset clears control and the pick count to 1; no clearing pass.
`default_nettype none

module k_nonadjacent_min_gap_select #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  kngs_in_if.sink                      points,
  kngs_out_if.source                   result,
  input  logic                         cfg_we,
  input  logic [kngs_pkg::PICKS_W-1:0] cfg_data
);

  logic [kngs_pkg::PICKS_W-1:0] picks;
  logic                         res_valid;
  logic                         res_take;
  kngs_pkg::res_t               res;
  logic                         out_valid;
  kngs_pkg::res_t               out_data;

  // pick count register
  always_ff @(posedge clk) begin
    if (rst) begin
      picks <= kngs_pkg::PICKS_W'(1);
    end else if (cfg_we) begin
      picks <= cfg_data;
    end
  end

  kngs_engine #(
    .MAX_POINTS(MAX_POINTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .points   (points),
    .picks    (picks),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  // output register
  assign res_take = res_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_data <= res;
  end

  assign result.valid        = out_valid;
  assign result.total_length = out_data.total_length;
  assign result.overflow     = out_data.overflow;

  // closing point starts the heap build, so input stalls next cycle
  a_close_stalls: assert property (@(posedge clk) disable iff (rst)
    (points.valid && points.ready && points.last_point) |=> !points.ready)
    else $error("request taken right after closing point");

  // a result moves only into a free output register
  a_take_free: assert property (@(posedge clk) disable iff (rst)
    res_take |-> (!result.valid || result.ready))
    else $error("result overwrote a pending request");

  a_take_shows: assert property (@(posedge clk) disable iff (rst)
    res_take |=> result.valid)
    else $error("result taken but not presented");

endmodule

`default_nettype wire
